// ----- rtl/aq_pkg.sv -----
package aq_pkg;

    localparam int AXIS_W = 18;
    localparam int ANG_W  = 18;
    localparam int UNIT_W = 16;
    localparam int THR_W  = 10;
    localparam int SUM_W  = 36;
    localparam int LEN_W  = 18;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 19;
    localparam int QUO_W  = 15;
    localparam int Q30_W  = 31;

    localparam logic [Q30_W-1:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [Q30_W-1:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [19:0]      TWO_OVER_PI_Q20 = 20'd667544;

    typedef struct packed {
        logic signed [UNIT_W-1:0] sn;
        logic signed [UNIT_W-1:0] cs;
    } sincos_t;

endpackage

// ----- rtl/aq_delay.sv -----
module aq_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// ----- rtl/aq_sqrt.sv -----
module aq_sqrt import aq_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] sum,
    output logic [LEN_W-1:0] root
);

    localparam int RW    = SUM_W + 1;
    localparam int STEPS = LEN_W;

    logic [RW-1:0] rem_w [STEPS+1];
    logic [RW-1:0] res_w [STEPS+1];

    assign rem_w[0] = RW'(sum);
    assign res_w[0] = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] BIT_K = RW'(1) << (2 * (STEPS - 1 - k));
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_reg;
        logic [RW-1:0] res_reg;

        assign trial = res_w[k] + BIT_K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_w[k] >= trial)
                begin
                    rem_reg <= rem_w[k] - trial;
                    res_reg <= (res_w[k] >> 1) + BIT_K;
                end
                else
                begin
                    rem_reg <= rem_w[k];
                    res_reg <= res_w[k] >> 1;
                end
            end
        end

        assign rem_w[k+1] = rem_reg;
        assign res_w[k+1] = res_reg;
    end

    assign root = res_w[STEPS][LEN_W-1:0];

endmodule

// ----- rtl/aq_div.sv -----
module aq_div import aq_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int DW = NUM_W + 1;

    logic [NUM_W-1:0] rem_w [QUO_W+1];
    logic [DEN_W-1:0] den_w [QUO_W+1];
    logic [QUO_W-1:0] quo_w [QUO_W+1];

    assign rem_w[0] = num;
    assign den_w[0] = den;
    assign quo_w[0] = '0;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_bit
        localparam int B = QUO_W - 1 - j;
        logic [DW-1:0]    dsh;
        logic             ge;
        logic [QUO_W-1:0] quo_next;
        logic [NUM_W-1:0] rem_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QUO_W-1:0] quo_reg;

        assign dsh = DW'(den_w[j]) << B;
        assign ge  = DW'(rem_w[j]) >= dsh;

        always_comb
        begin
            quo_next    = quo_w[j];
            quo_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= ge ? NUM_W'(DW'(rem_w[j]) - dsh) : rem_w[j];
                den_reg <= den_w[j];
                quo_reg <= quo_next;
            end
        end

        assign rem_w[j+1] = rem_reg;
        assign den_w[j+1] = den_reg;
        assign quo_w[j+1] = quo_reg;
    end

    assign quo = quo_w[QUO_W];

endmodule

// ----- rtl/aq_cdiv.sv -----
module aq_cdiv import aq_pkg::*; #(
    parameter int DIVISOR = 3
) (
    input  logic             clk,
    input  logic             en,
    input  logic [Q30_W-1:0] v,
    output logic [Q30_W-1:0] q
);

    localparam logic [Q30_W-1:0] RECIP = Q30_W'((64'd1 << Q30_W) / DIVISOR);
    localparam logic [Q30_W-1:0] DIV_K = Q30_W'(DIVISOR);

    logic [2*Q30_W-1:0] prod;
    logic [Q30_W-1:0]   q0_reg;
    logic [Q30_W-1:0]   v_reg;
    logic [Q30_W-1:0]   back;
    logic [Q30_W-1:0]   rem;
    logic [Q30_W-1:0]   q_reg;

    assign prod = (2*Q30_W)'(v) * (2*Q30_W)'(RECIP);
    assign back = q0_reg * DIV_K;
    assign rem  = v_reg - back;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= prod[2*Q30_W-1:Q30_W];
            v_reg  <= v;
            q_reg  <= q0_reg + Q30_W'(rem >= DIV_K);
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/aq_sincos.sv -----
module aq_sincos import aq_pkg::*; (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output sincos_t                 sc
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [ANG_W-1:0] ang_mag;
    logic [37:0]      ph_prod_reg;
    logic             neg1_reg;
    logic [37:0]      ph_sum;
    logic [22:0]      ph;
    logic [19:0]      frac;
    logic [19:0]      g2_reg;
    logic [1:0]       quad2_reg;
    logic             swap2_reg;
    logic             neg2_reg;
    logic [50:0]      xprod;
    logic [29:0]      x3_reg;
    logic [59:0]      x2prod;
    logic [29:0]      x2_4_reg;
    logic [29:0]      x4_reg;
    logic [29:0]      x2d2;
    logic [29:0]      x2d5;
    logic [29:0]      x2d8;
    logic [29:0]      xd8;
    logic [3:0]       flags9;

    assign ang_mag = angle[ANG_W-1] ? (~angle + 18'd1) : angle;
    assign ph_sum  = ph_prod_reg + 38'd16384;
    assign ph      = ph_sum[37:15];
    assign frac    = ph[19:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_prod_reg <= 38'(ang_mag) * 38'(TWO_OVER_PI_Q20);
            neg1_reg    <= angle[ANG_W-1];
            quad2_reg   <= ph[21:20];
            swap2_reg   <= frac[19];
            neg2_reg    <= neg1_reg;
            g2_reg      <= frac[19] ? 20'(21'h10_0000 - {1'b0, frac}) : frac;
            x3_reg      <= xprod[49:20];
            x2_4_reg    <= x2prod[59:30];
            x4_reg      <= x3_reg;
        end
    end

    assign xprod  = 51'(g2_reg) * 51'(HALF_PI_Q30);
    assign x2prod = 60'(x3_reg) * 60'(x3_reg);

    aq_delay #(.WIDTH(30), .DEPTH(2)) u_x2d2 (.clk(clk), .en(en), .d(x2_4_reg), .q(x2d2));
    aq_delay #(.WIDTH(30), .DEPTH(3)) u_x2d5 (.clk(clk), .en(en), .d(x2d2), .q(x2d5));
    aq_delay #(.WIDTH(30), .DEPTH(3)) u_x2d8 (.clk(clk), .en(en), .d(x2d5), .q(x2d8));
    aq_delay #(.WIDTH(30), .DEPTH(8)) u_xd8 (.clk(clk), .en(en), .d(x4_reg), .q(xd8));
    aq_delay #(.WIDTH(4), .DEPTH(11)) u_flags (
        .clk(clk), .en(en), .d({quad2_reg, swap2_reg, neg2_reg}), .q(flags9)
    );

    // sine series
    logic [Q30_W-1:0] sa, sb, sc3;
    logic [Q30_W-1:0] ss1, ss2, ss3;
    logic [60:0]      sm1p, sm2p, sfp;
    logic [Q30_W-1:0] sm1_reg, sm2_reg, sfin_reg;

    aq_cdiv #(.DIVISOR(42)) u_s42 (.clk(clk), .en(en), .v({1'b0, x2_4_reg}), .q(sa));
    assign ss1  = ONE_Q30 - sa;
    assign sm1p = 61'(x2d2) * 61'(ss1);
    aq_cdiv #(.DIVISOR(20)) u_s20 (.clk(clk), .en(en), .v(sm1_reg), .q(sb));
    assign ss2  = ONE_Q30 - sb;
    assign sm2p = 61'(x2d5) * 61'(ss2);
    aq_cdiv #(.DIVISOR(6)) u_s6 (.clk(clk), .en(en), .v(sm2_reg), .q(sc3));
    assign ss3  = ONE_Q30 - sc3;
    assign sfp  = 61'(xd8) * 61'(ss3);

    // cosine series
    logic [Q30_W-1:0] ca, cb, cc;
    logic [Q30_W-1:0] cc1, cc2, cc3;
    logic [60:0]      cm1p, cm2p, cm3p;
    logic [Q30_W-1:0] cm1_reg, cm2_reg;
    logic [29:0]      cm3_reg;
    logic [Q30_W-1:0] cfin;

    aq_cdiv #(.DIVISOR(56)) u_c56 (.clk(clk), .en(en), .v({1'b0, x2_4_reg}), .q(ca));
    assign cc1  = ONE_Q30 - ca;
    assign cm1p = 61'(x2d2) * 61'(cc1);
    aq_cdiv #(.DIVISOR(30)) u_c30 (.clk(clk), .en(en), .v(cm1_reg), .q(cb));
    assign cc2  = ONE_Q30 - cb;
    assign cm2p = 61'(x2d5) * 61'(cc2);
    aq_cdiv #(.DIVISOR(12)) u_c12 (.clk(clk), .en(en), .v(cm2_reg), .q(cc));
    assign cc3  = ONE_Q30 - cc;
    assign cm3p = 61'(x2d8) * 61'(cc3);
    assign cfin = ONE_Q30 - Q30_W'(cm3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm1_reg  <= sm1p[60:30];
            sm2_reg  <= sm2p[60:30];
            sfin_reg <= sfp[60:30];
            cm1_reg  <= cm1p[60:30];
            cm2_reg  <= cm2p[60:30];
            cm3_reg  <= cm3p[60:31];
        end
    end

    // round, fold quadrant, apply sign
    logic [31:0]              s_sum, c_sum;
    logic signed [UNIT_W-1:0] s_r, c_r, s0, c0;
    sincos_t                  sc_next;
    sincos_t                  sc_reg;

    assign s_sum = 32'(sfin_reg) + 32'd32768;
    assign c_sum = 32'(cfin) + 32'd32768;
    assign s_r   = {1'b0, s_sum[30:16]};
    assign c_r   = {1'b0, c_sum[30:16]};
    assign s0    = flags9[1] ? c_r : s_r;
    assign c0    = flags9[1] ? s_r : c_r;

    always_comb
    begin
        case (flags9[3:2])
            QUAD_0:
            begin
                sc_next.sn = s0;
                sc_next.cs = c0;
            end
            QUAD_1:
            begin
                sc_next.sn = c0;
                sc_next.cs = -s0;
            end
            QUAD_2:
            begin
                sc_next.sn = -s0;
                sc_next.cs = -c0;
            end
            default:
            begin
                sc_next.sn = -c0;
                sc_next.cs = s0;
            end
        endcase
        if (flags9[0])
        begin
            sc_next.sn = -sc_next.sn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

// ----- rtl/axis_angle_to_quaternion_guarded.sv -----
// Axis-angle to quaternion converter. Each transaction on s_* carries an axis (Q3.14)
// and an angle in radians (Q3.14); the matching m_* transaction carries the quaternion,
// the unit axis used (the raw axis, saturated, when its length is at or below
// zero_threshold) and the angle, all Q1.14 but the angle. One transaction is taken per
// cycle while s_tready is high; each result passes through the 18-stage square-root
// pipeline followed by the 15-stage divider that normalises each component.
// An output register plus one skid register hold results while m_tready is low;
// s_tready falls once the skid register fills. Write zero_threshold on cfg_* only
// while no transaction is in flight.
module axis_angle_to_quaternion_guarded import aq_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // axis_x, axis_y, axis_z, angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // quat_x, quat_y, quat_z, quat_w, unit_x, unit_y,
                                    // unit_z, angle_out, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [9:0]   cfg_data
);

    localparam int DEPTH = 40;
    localparam int OUT_W = 136;

    typedef struct packed {
        logic [AXIS_W-1:0]        mag;
        logic                     neg;
        logic signed [UNIT_W-1:0] sat;
    } axis_side_t;

    typedef struct packed {
        logic                     neg;
        logic signed [UNIT_W-1:0] sat;
    } unit_side_t;

    function automatic logic signed [UNIT_W-1:0] sat_unit(input logic signed [AXIS_W-1:0] v);
        logic signed [UNIT_W-1:0] r;
        if (v > 18'sd16384)
            r = 16'sd16384;
        else if (v < -18'sd16384)
            r = -16'sd16384;
        else
            r = v[UNIT_W-1:0];
        return r;
    endfunction

    logic [THR_W-1:0] thr_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic             skid_vld_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] skid_reg;
    logic             xfer;

    assign adv       = !skid_vld_reg;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign xfer      = adv && vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 10'd1;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // input and squares
    logic signed [AXIS_W-1:0] ax0_reg [3];
    logic signed [ANG_W-1:0]  ang0_reg;
    logic [AXIS_W-1:0]        mag0 [3];
    axis_side_t [2:0]         side1_reg;
    logic [SUM_W-1:0]         sq1_reg [3];
    logic [SUM_W-1:0]         sum2_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_mag
        assign mag0[i] = ax0_reg[i][AXIS_W-1] ? (~ax0_reg[i] + 18'd1) : ax0_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ax0_reg[i]       <= s_tdata[i*AXIS_W +: AXIS_W];
                side1_reg[i].mag <= mag0[i];
                side1_reg[i].neg <= ax0_reg[i][AXIS_W-1];
                side1_reg[i].sat <= sat_unit(ax0_reg[i]);
                sq1_reg[i]       <= SUM_W'(mag0[i]) * SUM_W'(mag0[i]);
            end
            ang0_reg <= s_tdata[3*AXIS_W +: ANG_W];
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        end
    end

    // length
    logic [LEN_W-1:0] len20;
    axis_side_t [2:0] side20;

    aq_sqrt u_sqrt (.clk(clk), .en(adv), .sum(sum2_reg), .root(len20));

    aq_delay #(.WIDTH($bits(axis_side_t) * 3), .DEPTH(19)) u_side20 (
        .clk(clk), .en(adv), .d(side1_reg), .q(side20)
    );

    // threshold and divider operands
    logic                     byp21_reg;
    logic [NUM_W-1:0]         num21_reg [3];
    logic [DEN_W-1:0]         den21_reg;
    unit_side_t [2:0]         uside21_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp21_reg <= len20 <= LEN_W'(thr_reg);
            den21_reg <= {len20, 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                num21_reg[i]       <= {side20[i].mag, 15'd0} + NUM_W'(len20);
                uside21_reg[i].neg <= side20[i].neg;
                uside21_reg[i].sat <= side20[i].sat;
            end
        end
    end

    logic [QUO_W-1:0] quo36 [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        aq_div u_div (
            .clk(clk), .en(adv), .num(num21_reg[i]), .den(den21_reg), .quo(quo36[i])
        );
    end

    logic             byp36;
    unit_side_t [2:0] uside36;

    aq_delay #(.WIDTH(1 + $bits(unit_side_t) * 3), .DEPTH(15)) u_side36 (
        .clk(clk), .en(adv), .d({byp21_reg, uside21_reg}), .q({byp36, uside36})
    );

    // sine and cosine of the half angle
    sincos_t                 sc14;
    sincos_t                 sc37;
    logic signed [ANG_W-1:0] ang37;

    aq_sincos u_sincos (.clk(clk), .en(adv), .angle(ang0_reg), .sc(sc14));

    aq_delay #(.WIDTH($bits(sincos_t)), .DEPTH(22)) u_sc37 (
        .clk(clk), .en(adv), .d(sc14), .q(sc37)
    );
    aq_delay #(.WIDTH(ANG_W), .DEPTH(36)) u_ang37 (
        .clk(clk), .en(adv), .d(ang0_reg), .q(ang37)
    );

    // unit axis, products, rounding
    logic signed [UNIT_W-1:0] un37_reg [3];
    sincos_t                  sc37_reg;
    logic signed [ANG_W-1:0]  ang37_reg;
    logic signed [UNIT_W-1:0] qsgn36 [3];
    logic [UNIT_W-1:0]        sn_abs;
    logic [UNIT_W-1:0]        un_abs [3];
    logic [29:0]              prod38_reg [3];
    logic                     qneg38_reg [3];
    logic signed [UNIT_W-1:0] un38_reg [3];
    logic signed [UNIT_W-1:0] cs38_reg;
    logic signed [ANG_W-1:0]  ang38_reg;
    logic [30:0]              rnd38 [3];
    logic signed [UNIT_W-1:0] quat38 [3];
    logic [OUT_W-1:0]         fin39_reg;

    assign sn_abs = sc37_reg.sn[UNIT_W-1] ? UNIT_W'(-sc37_reg.sn) : sc37_reg.sn;

    for (genvar i = 0; i < 3; i++)
    begin : g_unit
        assign qsgn36[i] = uside36[i].neg ? -$signed({1'b0, quo36[i]})
                                          : $signed({1'b0, quo36[i]});
        assign un_abs[i] = un37_reg[i][UNIT_W-1] ? UNIT_W'(-un37_reg[i]) : un37_reg[i];
        assign rnd38[i]  = 31'(prod38_reg[i]) + 31'd8192;
        assign quat38[i] = qneg38_reg[i] ? -$signed(rnd38[i][29:14])
                                         : $signed(rnd38[i][29:14]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                un37_reg[i]   <= byp36 ? uside36[i].sat : qsgn36[i];
                prod38_reg[i] <= 30'(un_abs[i][14:0]) * 30'(sn_abs[14:0]);
                qneg38_reg[i] <= sc37_reg.sn[UNIT_W-1] ^ un37_reg[i][UNIT_W-1];
                un38_reg[i]   <= un37_reg[i];
            end
            sc37_reg  <= sc37;
            ang37_reg <= ang37;
            cs38_reg  <= sc37_reg.cs;
            ang38_reg <= ang37_reg;
            fin39_reg <= {6'd0, ang38_reg, un38_reg[2], un38_reg[1], un38_reg[0],
                          cs38_reg, quat38[2], quat38[1], quat38[0]};
        end
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!m_tvalid_reg || m_tready)
        begin
            m_tvalid_reg <= skid_vld_reg || xfer;
            skid_vld_reg <= 1'b0;
        end
        else if (xfer)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_tvalid_reg || m_tready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : fin39_reg;
        end
        else if (xfer)
        begin
            skid_reg <= fin39_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- bench/axis_angle_to_quaternion_guarded_tb.sv -----
`timescale 1ns / 1ps

module axis_angle_to_quaternion_guarded_tb;

    typedef struct packed {
        logic signed [17:0] angle;
        logic signed [17:0] az;
        logic signed [17:0] ay;
        logic signed [17:0] ax;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] qx, qy, qz, qw, ux, uy, uz;
        logic signed [17:0] ang;
    } quat_t;

    localparam int LATENCY = 40;
    localparam int WATCHDOG = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [9:0]   cfg_data;

    pose_t       pose_queue[$];
    quat_t       quat_queue[$];
    logic [9:0]  threshold;
    logic        in_taken;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          results_seen;
    int          quiet_cycles;

    axis_angle_to_quaternion_guarded uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint scale_q14(longint a, longint b);
        longint m;
        m = (abs64(a) * abs64(b) + 8192) >>> 14;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic void half_angle_octant(longint g, output longint sn, output longint cs);
        longint unsigned one;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned c;
        one = 64'd1 << 30;
        x = (longint'(g) * 64'd1686629713) >> 20;
        x2 = (x * x) >> 30;
        s = one - x2 / 42;
        s = one - ((x2 * s) >> 30) / 20;
        s = one - ((x2 * s) >> 30) / 6;
        s = (x * s) >> 30;
        c = one - x2 / 56;
        c = one - ((x2 * c) >> 30) / 30;
        c = one - ((x2 * c) >> 30) / 12;
        c = one - ((x2 * c) >> 30) / 2;
        sn = longint'((s + 32768) >> 16);
        cs = longint'((c + 32768) >> 16);
    endfunction

    function automatic quat_t rotation_quat(pose_t p, logic [9:0] thr);
        quat_t  r;
        longint comp[3];
        longint unit[3];
        longint ang;
        longint sum;
        longint len;
        longint q;
        longint ph;
        longint frac;
        longint s0;
        longint c0;
        longint sn;
        longint cs;
        int     quad;
        comp[0] = p.ax;
        comp[1] = p.ay;
        comp[2] = p.az;
        ang = p.angle;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += comp[i] * comp[i];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            if (len <= thr)
                unit[i] = clamp_unit(comp[i]);
            else
            begin
                q = (abs64(comp[i]) * 32768 + len) / (2 * len);
                unit[i] = clamp_unit(comp[i] < 0 ? -q : q);
            end
        end
        ph = (abs64(ang) * 667544 + 16384) >>> 15;
        quad = int'((ph >> 20) & 3);
        frac = ph & 64'hFFFFF;
        if (frac < (64'd1 << 19))
            half_angle_octant(frac, s0, c0);
        else
            half_angle_octant((64'd1 << 20) - frac, c0, s0);
        case (quad)
            0: begin sn = s0; cs = c0; end
            1: begin sn = c0; cs = -s0; end
            2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        if (ang < 0) sn = -sn;
        r.qx = 16'(clamp_unit(scale_q14(sn, unit[0])));
        r.qy = 16'(clamp_unit(scale_q14(sn, unit[1])));
        r.qz = 16'(clamp_unit(scale_q14(sn, unit[2])));
        r.qw = 16'(clamp_unit(cs));
        r.ux = 16'(unit[0]);
        r.uy = 16'(unit[1]);
        r.uz = 16'(unit[2]);
        r.ang = p.angle;
        return r;
    endfunction

    function automatic logic [17:0] rand18();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'(int'($urandom_range(0, 64)) - 32);
            3: return 18'(int'($urandom_range(0, 32768)) - 16384);
            default: return 18'($urandom);
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pose_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pose_queue[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // pop the pending item once its transaction completes
    always @(posedge clk)
    begin
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
        begin
            quat_queue.push_back(rotation_quat(pose_queue[0], threshold));
            pose_queue.pop_front();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        quat_t exp_q;
        quat_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.qx  = m_tdata[15:0];
            got.qy  = m_tdata[31:16];
            got.qz  = m_tdata[47:32];
            got.qw  = m_tdata[63:48];
            got.ux  = m_tdata[79:64];
            got.uy  = m_tdata[95:80];
            got.uz  = m_tdata[111:96];
            got.ang = m_tdata[129:112];
            results_seen++;
            if (quat_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_q = quat_queue.pop_front();
                if (got != exp_q)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp q=%0d,%0d,%0d,%0d u=%0d,%0d,%0d a=%0d",
                                  " got q=%0d,%0d,%0d,%0d u=%0d,%0d,%0d a=%0d"},
                                 exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.ux, exp_q.uy,
                                 exp_q.uz, exp_q.ang, got.qx, got.qy, got.qz, got.qw,
                                 got.ux, got.uy, got.uz, got.ang);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("timeout with %0d results outstanding", quat_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_threshold(input logic [9:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        threshold = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pose_queue.size() != 0 || quat_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_pose(input logic [17:0] x, y, z, a);
        pose_t p;
        p.ax = x;
        p.ay = y;
        p.az = z;
        p.angle = a;
        pose_queue.push_back(p);
    endtask

    task automatic add_random_poses(input int n);
        for (int i = 0; i < n; i++)
            add_pose(rand18(), rand18(), rand18(), rand18());
    endtask

    initial
    begin
        logic [9:0] thr_steps[4];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        threshold = 10'd1;
        in_taken = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 48;
        mismatches = 0;
        results_seen = 0;
        quiet_cycles = 0;
        thr_steps = '{10'd0, 10'd1023, 10'd300, 10'd1};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_pose(18'd0, 18'd0, 18'd0, 18'd0);
        add_pose(18'd1, 18'd0, 18'd0, 18'd25736);
        add_pose(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        add_pose(18'h20000, 18'h20000, 18'h20000, 18'h20000);
        add_pose(18'd16384, 18'd0, 18'd0, 18'd51472);
        add_pose(18'd0, 18'h3C000, 18'd0, 18'h33BB0);
        add_pose(18'd0, 18'd0, 18'd16384, 18'd12868);
        add_pose(18'h20000, 18'd0, 18'd0, 18'd0);
        add_pose(18'd0, 18'd1, 18'h3FFFF, 18'd77208);
        add_pose(18'd3, 18'd4, 18'd0, 18'd102944);
        add_pose(18'd9000, 18'h3DCD8, 18'd500, 18'h20001);
        add_pose(18'd0, 18'd0, 18'd1, 18'h3FFFF);
        add_random_poses(8);
        drain();

        write_threshold(10'd1023);
        add_pose(18'd600, 18'd600, 18'd600, 18'd1234);
        add_pose(18'h3FC00, 18'd10, 18'd0, 18'h3F000);
        add_random_poses(100);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 48 : 0;
            recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 31 : 0;
            for (int k = 0; k < 4; k++)
            begin
                write_threshold(thr_steps[k]);
                for (int i = 0; i < 70; i++)
                    add_pose(18'(int'($urandom_range(0, 2400)) - 1200),
                             18'(int'($urandom_range(0, 2400)) - 1200),
                             18'(int'($urandom_range(0, 2400)) - 1200), rand18());
                add_random_poses(70);
                drain();
            end
        end

        $display("covered %0d conversions over thresholds 0, 1, 300 and 1023", results_seen);
        $display("with short, long, zero and full-scale axes and angles at both extremes");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
